// ===== rtl/core/pqe_pkg.sv =====
// Shared types and codes for the product quantizer encode/distance block.
`timescale 1ns / 1ps
`default_nettype none
package pqe_pkg;

  localparam logic [2:0] OP_LOAD   = 3'd0;
  localparam logic [2:0] OP_ENCODE = 3'd1;
  localparam logic [2:0] OP_QUERY  = 3'd2;
  localparam logic [2:0] OP_SCORE  = 3'd3;
  localparam logic [2:0] OP_DECODE = 3'd4;

  localparam logic [1:0] KIND_CODE     = 2'd0;
  localparam logic [1:0] KIND_DISTANCE = 2'd1;
  localparam logic [1:0] KIND_ELEMENT  = 2'd2;

  localparam logic [1:0] REG_NUM_SUBQUANTIZERS = 2'd0;
  localparam logic [1:0] REG_SUB_DIMENSION     = 2'd1;

  localparam int PSUM_W = 40;
  localparam int SUM_W  = 48;

  typedef struct packed {
    logic              valid;
    logic [PSUM_W-1:0] psum;
  } tok_t;

endpackage
`default_nettype wire

// ===== rtl/core/pqe_if.sv =====
// Input and result channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface pqe_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        operation;
  logic [3:0]        sub_index;
  logic [7:0]        centroid_index;
  logic [2:0]        dim_index;
  logic signed [15:0] value;
  logic [7:0]        code_byte;

  modport source (output valid, operation, sub_index, centroid_index, dim_index, value,
                  code_byte, input ready);
  modport sink (input valid, operation, sub_index, centroid_index, dim_index, value,
                code_byte, output ready);
endinterface

interface pqe_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         code_out;
  logic [47:0]        distance;
  logic signed [15:0] element_out;
  logic               last;

  modport source (output valid, kind, code_out, distance, element_out, last, input ready);
  modport sink (input valid, kind, code_out, distance, element_out, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pqe_cell.sv =====
// One lane of the distance chain: codebook bank, buffered element, squared difference.
`timescale 1ns / 1ps
`default_nettype none
module pqe_cell #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 mem_we,
  input  wire [AW-1:0]        mem_waddr,
  input  wire [15:0]          mem_wdata,
  input  wire                 buf_we,
  input  wire [15:0]          buf_wdata,
  input  wire                 active,
  input  wire                 dec_rd,
  input  wire [AW-1:0]        dec_addr,
  input  wire pqe_pkg::tok_t  tok_i,
  input  wire [AW-1:0]        addr_i,
  output pqe_pkg::tok_t       tok_o,
  output logic [AW-1:0]       addr_o,
  output logic signed [15:0]  elem
);

  logic [15:0]        bank [DEPTH];
  logic signed [15:0] buf_r;
  pqe_pkg::tok_t      a_tok;
  pqe_pkg::tok_t      b_tok;
  logic [AW-1:0]      a_addr;
  logic [AW-1:0]      b_addr;
  logic [32:0]        sq;
  logic signed [16:0] diff;
  logic signed [33:0] prod;

  assign diff = {buf_r[15], buf_r} - {elem[15], elem};
  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bank[mem_waddr] <= mem_wdata;
    end
    if (dec_rd) begin
      elem <= bank[dec_addr];
    end else if (tok_i.valid) begin
      elem <= bank[addr_i];
    end
  end

  always_ff @(posedge clk) begin
    a_tok.psum <= tok_i.psum;
    a_addr     <= addr_i;
    b_tok.psum <= a_tok.psum;
    b_addr     <= a_addr;
    sq         <= active ? prod[32:0] : '0;
    tok_o.psum <= b_tok.psum + pqe_pkg::PSUM_W'(sq);
    addr_o     <= b_addr;
    if (rst) begin
      buf_r       <= '0;
      a_tok.valid <= 1'b0;
      b_tok.valid <= 1'b0;
      tok_o.valid <= 1'b0;
    end else begin
      if (buf_we) begin
        buf_r <= buf_wdata;
      end
      a_tok.valid <= tok_i.valid;
      b_tok.valid <= a_tok.valid;
      tok_o.valid <= b_tok.valid;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/product_quantizer_encode_adc_unit.sv =====
// Top level: product quantizer encode, distance table, scoring and decode.
`timescale 1ns / 1ps
`default_nettype none
// Items are taken one at a time. A load, and an element that does not complete a
// subvector, leave the unit idle; a score passes through the score state, and a decode
// sends one result per element of the subvector. Results also wait while the output is
// held off. An encode or query element that completes a subvector streams all CENTROIDS
// centroids through a chain of MAX_SUB_DIMENSION cells (three stages each), and no new
// item is taken until the last centroid has left the chain. The codebook is banked, one
// bank per cell. Codebook and distance table hold garbage until written; no clearing
// pass is needed. Config writes must come only while idle.
module product_quantizer_encode_adc_unit #(
  parameter int CENTROIDS         = 256,
  parameter int MAX_SUBQUANTIZERS = 16,
  parameter int MAX_SUB_DIMENSION = 8
) (
  input  wire          clk,
  input  wire          rst,
  pqe_in_if.sink       in_ch,
  pqe_out_if.source    out_ch,
  input  wire          cfg_we,
  input  wire [1:0]    cfg_index,
  input  wire [4:0]    cfg_data
);

  localparam int KW = $clog2(CENTROIDS);
  localparam int SW = (MAX_SUBQUANTIZERS > 1) ? $clog2(MAX_SUBQUANTIZERS) : 1;
  localparam int JW = (MAX_SUB_DIMENSION > 1) ? $clog2(MAX_SUB_DIMENSION) : 1;
  localparam int MW = $clog2(MAX_SUBQUANTIZERS + 1);
  localparam int DW = $clog2(MAX_SUB_DIMENSION + 1);
  localparam int TD = MAX_SUBQUANTIZERS * CENTROIDS;
  localparam int TW = (TD > 1) ? $clog2(TD) : 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RUN     = 3'd1;
  localparam logic [2:0] S_ENC_OUT = 3'd2;
  localparam logic [2:0] S_SCORE   = 3'd3;
  localparam logic [2:0] S_DEC_OUT = 3'd4;

  logic [2:0]  state;
  logic [4:0]  num_sq;
  logic [3:0]  sub_dim;
  logic [MW-1:0] m_eff;
  logic [DW-1:0] d_eff;
  logic [JW-1:0] ej;
  logic [SW-1:0] es;
  logic [SW-1:0] cp;
  logic [pqe_pkg::SUM_W-1:0] dsum;
  logic [SW-1:0] run_sub;
  logic          run_enc;
  logic [TW-1:0] base;
  logic          feeding;
  logic [KW-1:0] fk;
  logic [KW-1:0] gk;
  logic [KW-1:0] best_k;
  logic [pqe_pkg::PSUM_W-1:0] best;
  logic [JW-1:0] dj;
  logic [pqe_pkg::PSUM_W-1:0] tbl_rd;
  logic [pqe_pkg::PSUM_W-1:0] dtable [TD];

  logic        acc;
  logic        out_free;
  logic        out_set;
  logic        is_elem;
  logic        is_load;
  logic        load_ok;
  logic [TW-1:0] load_addr;
  logic [KW-1:0] code_c;
  logic [TW-1:0] code_addr;
  logic        dec_rd;
  logic        run_last;
  logic        cfg_hit;

  pqe_pkg::tok_t tok  [MAX_SUB_DIMENSION + 1];
  logic [TW-1:0] taddr [MAX_SUB_DIMENSION + 1];
  logic signed [15:0] elem [MAX_SUB_DIMENSION];

  always_comb begin
    if (num_sq == '0) begin
      m_eff = MW'(1);
    end else if (int'(num_sq) > MAX_SUBQUANTIZERS) begin
      m_eff = MW'(MAX_SUBQUANTIZERS);
    end else begin
      m_eff = MW'(num_sq);
    end
    if (sub_dim == '0) begin
      d_eff = DW'(1);
    end else if (int'(sub_dim) > MAX_SUB_DIMENSION) begin
      d_eff = DW'(MAX_SUB_DIMENSION);
    end else begin
      d_eff = DW'(sub_dim);
    end
  end

  assign in_ch.ready = (state == S_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;
  assign out_free    = !out_ch.valid || out_ch.ready;
  assign out_set     = out_free && ((state == S_ENC_OUT) || (state == S_DEC_OUT) ||
                                    (state == S_SCORE && run_last));
  assign is_elem     = (in_ch.operation == pqe_pkg::OP_ENCODE) ||
                       (in_ch.operation == pqe_pkg::OP_QUERY);
  assign is_load     = acc && (in_ch.operation == pqe_pkg::OP_LOAD);
  assign load_ok     = (int'(in_ch.sub_index) < MAX_SUBQUANTIZERS) &&
                       (int'(in_ch.centroid_index) < CENTROIDS) &&
                       (int'(in_ch.dim_index) < MAX_SUB_DIMENSION);
  assign load_addr   = TW'(int'(in_ch.sub_index) * CENTROIDS + int'(in_ch.centroid_index));
  assign code_c      = (int'(in_ch.code_byte) >= CENTROIDS) ? KW'(CENTROIDS - 1)
                                                            : KW'(in_ch.code_byte);
  assign code_addr   = TW'(int'(cp) * CENTROIDS + int'(code_c));
  assign dec_rd      = acc && (in_ch.operation == pqe_pkg::OP_DECODE);
  assign run_last    = (int'(run_sub) + 1 == int'(m_eff));
  assign cfg_hit     = cfg_we && ((cfg_index == pqe_pkg::REG_NUM_SUBQUANTIZERS) ||
                                  (cfg_index == pqe_pkg::REG_SUB_DIMENSION));

  assign tok[0].valid = feeding;
  assign tok[0].psum  = '0;
  assign taddr[0]     = base + TW'(fk);

  for (genvar j = 0; j < MAX_SUB_DIMENSION; j++) begin : g_cell
    pqe_cell #(.DEPTH(TD), .AW(TW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .mem_we    (is_load && load_ok && (int'(in_ch.dim_index) == j)),
      .mem_waddr (load_addr),
      .mem_wdata (in_ch.value),
      .buf_we    (acc && is_elem && (int'(ej) == j)),
      .buf_wdata (in_ch.value),
      .active    (j < int'(d_eff)),
      .dec_rd    (dec_rd),
      .dec_addr  (code_addr),
      .tok_i     (tok[j]),
      .addr_i    (taddr[j]),
      .tok_o     (tok[j+1]),
      .addr_o    (taddr[j+1]),
      .elem      (elem[j])
    );
  end

  always_ff @(posedge clk) begin
    if (state == S_RUN && tok[MAX_SUB_DIMENSION].valid && !run_enc) begin
      dtable[base + TW'(gk)] <= tok[MAX_SUB_DIMENSION].psum;
    end
    if (acc && in_ch.operation == pqe_pkg::OP_SCORE) begin
      tbl_rd <= dtable[code_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      num_sq       <= 5'd16;
      sub_dim      <= 4'd8;
      ej           <= '0;
      es           <= '0;
      cp           <= '0;
      dsum         <= '0;
      feeding      <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && !out_set) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            if (is_elem) begin
              if (int'(ej) + 1 < int'(d_eff)) begin
                ej <= ej + 1'b1;
              end else begin
                ej      <= '0;
                es      <= (int'(es) + 1 == int'(m_eff)) ? '0 : es + 1'b1;
                run_sub <= es;
                run_enc <= (in_ch.operation == pqe_pkg::OP_ENCODE);
                base    <= TW'(int'(es) * CENTROIDS);
                feeding <= 1'b1;
                fk      <= '0;
                gk      <= '0;
                state   <= S_RUN;
              end
            end else if (in_ch.operation == pqe_pkg::OP_SCORE) begin
              run_sub <= cp;
              state   <= S_SCORE;
            end else if (in_ch.operation == pqe_pkg::OP_DECODE) begin
              run_sub <= cp;
              dj      <= '0;
              state   <= S_DEC_OUT;
            end
          end
        end
        S_RUN: begin
          if (feeding) begin
            if (int'(fk) == CENTROIDS - 1) begin
              feeding <= 1'b0;
            end else begin
              fk <= fk + 1'b1;
            end
          end
          if (tok[MAX_SUB_DIMENSION].valid) begin
            if (gk == '0 || tok[MAX_SUB_DIMENSION].psum < best) begin
              best   <= tok[MAX_SUB_DIMENSION].psum;
              best_k <= gk;
            end
            gk <= gk + 1'b1;
            if (int'(gk) == CENTROIDS - 1) begin
              state <= run_enc ? S_ENC_OUT : S_IDLE;
            end
          end
        end
        S_ENC_OUT: begin
          if (out_free) begin
            out_ch.valid       <= 1'b1;
            out_ch.kind        <= pqe_pkg::KIND_CODE;
            out_ch.code_out    <= 8'(best_k);
            out_ch.distance    <= '0;
            out_ch.element_out <= '0;
            out_ch.last        <= run_last;
            state              <= S_IDLE;
          end
        end
        S_SCORE: begin
          if (!run_last) begin
            dsum  <= dsum + pqe_pkg::SUM_W'(tbl_rd);
            cp    <= cp + 1'b1;
            state <= S_IDLE;
          end else if (out_free) begin
            out_ch.valid       <= 1'b1;
            out_ch.kind        <= pqe_pkg::KIND_DISTANCE;
            out_ch.code_out    <= '0;
            out_ch.distance    <= dsum + pqe_pkg::SUM_W'(tbl_rd);
            out_ch.element_out <= '0;
            out_ch.last        <= 1'b1;
            dsum               <= '0;
            cp                 <= '0;
            state              <= S_IDLE;
          end
        end
        S_DEC_OUT: begin
          if (out_free) begin
            out_ch.valid       <= 1'b1;
            out_ch.kind        <= pqe_pkg::KIND_ELEMENT;
            out_ch.code_out    <= '0;
            out_ch.distance    <= '0;
            out_ch.element_out <= elem[dj];
            out_ch.last        <= run_last && (int'(dj) + 1 == int'(d_eff));
            if (int'(dj) + 1 == int'(d_eff)) begin
              state <= S_IDLE;
              if (run_last) begin
                cp   <= '0;
                dsum <= '0;
              end else begin
                cp <= cp + 1'b1;
              end
            end else begin
              dj <= dj + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_hit) begin
        if (cfg_index == pqe_pkg::REG_NUM_SUBQUANTIZERS) begin
          num_sq <= cfg_data;
        end else begin
          sub_dim <= cfg_data[3:0];
        end
        ej   <= '0;
        es   <= '0;
        cp   <= '0;
        dsum <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_chain_empty_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !tok[MAX_SUB_DIMENSION].valid)
    else $error("chain output valid while idle");
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> (ej == '0 && es == '0 && cp == '0 && dsum == '0))
    else $error("config write did not clear positions");
  a_cp_range: assert property (@(posedge clk) disable iff (rst)
    int'(cp) < int'(m_eff))
    else $error("code position out of range");
`endif

endmodule
`default_nettype wire
